/* rtl/fafs_pkg.sv */
// Package: item types, register indexes, defaults and helpers for the arming supervisor.
package fafs_pkg;

    // Timestamp bits used for elapsed-time math (16 to 32).
    localparam int TIME_BITS = 32;

    // Configuration register indexes.
    localparam logic [2:0] REG_ARMING_DELAY  = 3'd0;
    localparam logic [2:0] REG_FLYING_THR    = 3'd1;
    localparam logic [2:0] REG_FAILSAFE_THR  = 3'd2;
    localparam logic [2:0] REG_ARM_THR_MAX   = 3'd3;
    localparam logic [2:0] REG_ARM_STICK_MAX = 3'd4;
    localparam logic [2:0] REG_ARM_TILT_MAX  = 3'd5;

    // Register reset values.
    localparam logic [15:0] ARMING_DELAY_RST  = 16'd500;
    localparam logic [15:0] FLYING_THR_RST    = 16'd6554;
    localparam logic [15:0] FAILSAFE_THR_RST  = 16'd19661;
    localparam logic [15:0] ARM_THR_MAX_RST   = 16'd3277;
    localparam logic [14:0] ARM_STICK_MAX_RST = 15'd1638;
    localparam logic [14:0] ARM_TILT_MAX_RST  = 15'd1000;

    // Mode switch positions and modes.
    localparam logic [1:0] MODE_SW_ACRO = 2'd2;
    localparam logic [1:0] MODE_SW_KEEP = 2'd3;
    localparam logic       MODE_STAB    = 1'b0;
    localparam logic       MODE_ACRO    = 1'b1;

    // floor(x / 1000) for any 32-bit x: (x * DIV_MAGIC) >> DIV_SHIFT.
    localparam int          MAGIC_W   = 29;
    localparam logic [28:0] DIV_MAGIC = 29'h10624DD3;
    localparam int          DIV_SHIFT = 38;
    localparam int          PROD_W    = 32 + MAGIC_W;
    localparam int          SECS_W    = 23;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic               imu_ready;
        logic               calibrating;
        logic               rc_link_up;
        logic               arm_req;
        logic [1:0]         mode_sel;
        logic [15:0]        throttle_stick;
        logic signed [15:0] roll_cmd;
        logic signed [15:0] pitch_cmd;
        logic signed [15:0] body_roll;
        logic signed [15:0] body_pitch;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        flight_state;
        logic              flight_mode;
        logic              failsafe_on;
        logic              arm_attempted;
        logic [2:0]        arm_check;
        logic [15:0]       throttle_target;
        logic              run_control;
        logic              pid_clear;
        logic [SECS_W-1:0] flight_seconds;
    } out_item_t;

    // Magnitude of a 16-bit signed value; -32768 gives 32768.
    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [15:0] neg;
        neg = 16'(-v);
        return v[15] ? neg : 16'(v);
    endfunction

endpackage

/* rtl/flight_arming_failsafe_supervisor_top.sv */
// Top level: arming, failsafe and mode supervisor with a three-register item pipeline.
// An accepted item passes the input, mid and result registers in turn before its result is valid.
// Throughput: one item per cycle unless m_ready stalls the result; the state update is
//   combinational, and the seconds divide is a constant multiply registered in stage 3.
// A stalled result holds every stage behind it; bubbles are absorbed on the way.
// Reset (aresetn low, synchronous): state to disarmed, config to defaults, pipeline empty.
module flight_arming_failsafe_supervisor_top (
    input  logic                aclk,
    input  logic                aresetn,
    // item input
    input  logic                s_valid,
    output logic                s_ready,
    input  fafs_pkg::in_item_t  s_item,
    // result output
    output logic                m_valid,
    input  logic                m_ready,
    output fafs_pkg::out_item_t m_item,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_addr,
    input  logic [15:0]         cfg_data
);
    import fafs_pkg::*;

    typedef enum logic [2:0] {
        ST_DISARMED = 3'd0,
        ST_ARMING   = 3'd1,
        ST_ARMED    = 3'd2,
        ST_FLYING   = 3'd3,
        ST_FAILSAFE = 3'd4
    } flight_state_t;

    // Arm check result codes; rc lost and calibrating cannot occur once the
    // check runs (link is up, calibration already fails the sensor step).
    typedef enum logic [2:0] {
        CHK_OK       = 3'd0,
        CHK_SENSOR   = 3'd1,
        CHK_RC_LOST  = 3'd2,
        CHK_CALIB    = 3'd3,
        CHK_THROTTLE = 3'd4,
        CHK_STICKS   = 3'd5,
        CHK_TILT     = 3'd6
    } arm_check_t;

    // Stage 2 holds everything but the seconds, plus the flight time to divide.
    typedef struct packed {
        out_item_t      res;
        logic [31:0]    elapsed;
    } mid_item_t;

    // ---------------- configuration registers ----------------
    logic [15:0] arming_delay_reg, flying_thr_reg, failsafe_thr_reg, arm_thr_max_reg;
    logic [14:0] arm_stick_max_reg, arm_tilt_max_reg;

    // ---------------- supervisor state ----------------
    flight_state_t        cur_state_reg, cur_state_next;
    flight_state_t        saved_state_reg, saved_state_next;
    logic                 cur_mode_reg, cur_mode_next;
    logic                 failsafe_reg, failsafe_next;
    logic [15:0]          throttle_hold_reg, throttle_hold_next;
    logic [TIME_BITS-1:0] arm_start_reg, arm_start_next;
    logic [TIME_BITS-1:0] flight_start_reg, flight_start_next;

    // ---------------- pipeline ----------------
    logic        v1_reg, v2_reg, v3_reg;
    in_item_t    in_reg;
    mid_item_t   mid_reg, mid_next;
    out_item_t   res3_reg;
    logic [PROD_W-1:0] prod_reg;

    logic adv2, adv3, step;

    // Each stage moves when the one after it has room.
    assign adv3    = !v3_reg || m_ready;
    assign adv2    = !v2_reg || adv3;
    assign s_ready = !v1_reg || adv2;
    assign step    = v1_reg && adv2;   // item in stage 1 updates state now

    assign cfg_ready = 1'b1;

    // ---------------- per-item supervisor logic ----------------
    logic                 sensors_ok, link, attempted, run, clear, mode_req;
    arm_check_t           check;
    logic [TIME_BITS-1:0] now_t, arm_elapsed, fly_elapsed;

    always_comb begin
        now_t      = in_reg.now_ms[TIME_BITS-1:0];
        link       = in_reg.rc_link_up;
        sensors_ok = in_reg.imu_ready && !in_reg.calibrating;
        attempted  = 1'b0;
        run        = 1'b0;
        clear      = 1'b0;
        check      = CHK_OK;
        mode_req   = (in_reg.mode_sel == MODE_SW_ACRO) ? MODE_ACRO : MODE_STAB;

        cur_state_next     = cur_state_reg;
        saved_state_next   = saved_state_reg;
        cur_mode_next      = cur_mode_reg;
        failsafe_next      = failsafe_reg;
        throttle_hold_next = throttle_hold_reg;
        arm_start_next     = arm_start_reg;
        flight_start_next  = flight_start_reg;

        // Switches act only with the radio link up.
        if (link) begin
            throttle_hold_next = in_reg.throttle_stick;
            if (in_reg.arm_req && cur_state_reg == ST_DISARMED) begin
                attempted = 1'b1;
                if (!sensors_ok) begin
                    check = CHK_SENSOR;
                end else if (in_reg.throttle_stick > arm_thr_max_reg) begin
                    check = CHK_THROTTLE;
                end else if (mag16(in_reg.roll_cmd) > {1'b0, arm_stick_max_reg} ||
                             mag16(in_reg.pitch_cmd) > {1'b0, arm_stick_max_reg}) begin
                    check = CHK_STICKS;
                end else if (mag16(in_reg.body_roll) > {1'b0, arm_tilt_max_reg} ||
                             mag16(in_reg.body_pitch) > {1'b0, arm_tilt_max_reg}) begin
                    check = CHK_TILT;
                end
                if (check == CHK_OK) begin
                    cur_state_next = ST_ARMING;
                    arm_start_next = now_t;
                    clear          = 1'b1;
                end
            end else if (!in_reg.arm_req && cur_state_reg != ST_DISARMED) begin
                cur_state_next = ST_DISARMED;
                clear          = 1'b1;
            end
            if (in_reg.mode_sel != MODE_SW_KEEP && mode_req != cur_mode_reg) begin
                cur_mode_next = mode_req;
                clear         = 1'b1;
            end
        end

        // Failsafe entry on link loss, recovery to the saved state.
        if (!link && cur_state_next != ST_DISARMED) begin
            if (!failsafe_reg) begin
                saved_state_next = cur_state_next;
            end
            failsafe_next  = 1'b1;
            cur_state_next = ST_FAILSAFE;
        end else if (link && failsafe_reg) begin
            failsafe_next = 1'b0;
            if (cur_state_next == ST_FAILSAFE) begin
                cur_state_next = saved_state_reg;
            end
        end

        arm_elapsed = now_t - arm_start_next;

        case (cur_state_next)
            ST_ARMING: begin
                if (arm_elapsed > TIME_BITS'(arming_delay_reg)) begin
                    cur_state_next = ST_ARMED;
                end
            end
            ST_ARMED, ST_FLYING: begin
                // Sensor fault: no prior state saved here.
                if (!sensors_ok) begin
                    failsafe_next  = 1'b1;
                    cur_state_next = ST_FAILSAFE;
                end else begin
                    run = 1'b1;
                    if (throttle_hold_next > flying_thr_reg &&
                        cur_state_next == ST_ARMED) begin
                        cur_state_next    = ST_FLYING;
                        flight_start_next = now_t;
                    end
                end
            end
            ST_FAILSAFE: begin
                throttle_hold_next = failsafe_thr_reg;
                run                = 1'b1;
            end
            default: begin
            end
        endcase

        fly_elapsed = now_t - flight_start_next;

        mid_next.res.flight_state    = cur_state_next;
        mid_next.res.flight_mode     = cur_mode_next;
        mid_next.res.failsafe_on     = failsafe_next;
        mid_next.res.arm_attempted   = attempted;
        mid_next.res.arm_check       = check;
        mid_next.res.throttle_target = throttle_hold_next;
        mid_next.res.run_control     = run;
        mid_next.res.pid_clear       = clear;
        mid_next.res.flight_seconds  = '0;   // filled in stage 3
        mid_next.elapsed = (cur_state_next == ST_FLYING) ? 32'(fly_elapsed) : 32'd0;
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arming_delay_reg  <= ARMING_DELAY_RST;
            flying_thr_reg    <= FLYING_THR_RST;
            failsafe_thr_reg  <= FAILSAFE_THR_RST;
            arm_thr_max_reg   <= ARM_THR_MAX_RST;
            arm_stick_max_reg <= ARM_STICK_MAX_RST;
            arm_tilt_max_reg  <= ARM_TILT_MAX_RST;
            cur_state_reg     <= ST_DISARMED;
            saved_state_reg   <= ST_DISARMED;
            cur_mode_reg      <= MODE_STAB;
            failsafe_reg      <= 1'b0;
            throttle_hold_reg <= '0;
            arm_start_reg     <= '0;
            flight_start_reg  <= '0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_ARMING_DELAY:  arming_delay_reg  <= cfg_data;
                    REG_FLYING_THR:    flying_thr_reg    <= cfg_data;
                    REG_FAILSAFE_THR:  failsafe_thr_reg  <= cfg_data;
                    REG_ARM_THR_MAX:   arm_thr_max_reg   <= cfg_data;
                    REG_ARM_STICK_MAX: arm_stick_max_reg <= cfg_data[14:0];
                    REG_ARM_TILT_MAX:  arm_tilt_max_reg  <= cfg_data[14:0];
                    default: begin
                    end
                endcase
            end
            if (step) begin
                cur_state_reg     <= cur_state_next;
                saved_state_reg   <= saved_state_next;
                cur_mode_reg      <= cur_mode_next;
                failsafe_reg      <= failsafe_next;
                throttle_hold_reg <= throttle_hold_next;
                arm_start_reg     <= arm_start_next;
                flight_start_reg  <= flight_start_next;
            end
            v1_reg <= (s_valid && s_ready) || (v1_reg && !adv2);
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (adv2) begin
            mid_reg <= mid_next;
        end
        if (adv3) begin
            res3_reg <= mid_reg.res;
            prod_reg <= PROD_W'(mid_reg.elapsed) * PROD_W'(DIV_MAGIC);
        end
    end

    always_comb begin
        m_item                = res3_reg;
        m_item.flight_seconds = prod_reg[DIV_SHIFT +: SECS_W];
    end

    assign m_valid = v3_reg;

endmodule
